// File: rtl/pwc_pkg.sv
package pwc_pkg;

  localparam int NUM_BUCKETS    = 26;
  localparam int WORD_LEN       = 16;
  localparam int BUCKET_ENTRIES = 64;
  localparam int MAX_RESULTS    = 8;

  localparam int LEN_W  = $clog2(WORD_LEN + 1);
  localparam int POS_W  = $clog2(WORD_LEN);
  localparam int SLOT_W = $clog2(BUCKET_ENTRIES);
  localparam int CNT_W  = $clog2(BUCKET_ENTRIES + 1);
  localparam int BKT_W  = 5;
  localparam int ADDR_W = BKT_W + SLOT_W;
  localparam int MEM_DEPTH = NUM_BUCKETS * BUCKET_ENTRIES;
  localparam int QDEPTH = 2;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_BADFIRST = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_MATCH    = 3'd4;
  localparam logic [2:0] ST_NOMATCH  = 3'd5;
  localparam logic [2:0] ST_READ     = 3'd6;
  localparam logic [2:0] ST_LONG     = 3'd7;

  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LZ = 8'h7a;
  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UZ = 8'h5a;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  typedef struct packed {
    logic [1:0]                kind;
    logic [WORD_LEN-1:0][7:0]  chars;
    logic [LEN_W-1:0]          len;
    logic                      ovf;
    logic [BKT_W-1:0]          bucket;
    logic [SLOT_W-1:0]         slot;
    logic [POS_W-1:0]          position;
  } cmd_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  status;
    logic [5:0]  slot;
    logic [7:0]  chr;
    logic [3:0]  idx;
    logic        last;
  } res_t;

endpackage

// File: rtl/pwc_front.sv
module pwc_front import pwc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [1:0] opcode_i,
  input  logic [7:0] char_code_i,
  input  logic       last_i,
  input  logic [4:0] bucket_i,
  input  logic [5:0] slot_i,
  input  logic [3:0] position_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic [WORD_LEN-1:0][7:0] buf_q, buf_d;
  logic [LEN_W-1:0]         len_q, len_d;
  logic                     ovf_q, ovf_d;
  logic [7:0]               ch_lc;

  always_comb begin
    ch_lc = char_code_i;
    if (opcode_i == OP_QUERY && char_code_i >= CHAR_UA && char_code_i <= CHAR_UZ) begin
      ch_lc = char_code_i + CASE_OFFSET;
    end
    buf_d  = buf_q;
    len_d  = len_q;
    ovf_d  = ovf_q;
    push_o = 1'b0;
    cmd_o  = '0;
    cmd_o.kind     = opcode_i;
    cmd_o.bucket   = bucket_i;
    cmd_o.slot     = slot_i;
    cmd_o.position = position_i;
    if (accept_i && (opcode_i == OP_INSERT || opcode_i == OP_QUERY)) begin
      if (len_q < LEN_W'(WORD_LEN)) begin
        buf_d[len_q[POS_W-1:0]] = ch_lc;
        len_d = len_q + LEN_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
      if (last_i) begin
        push_o      = 1'b1;
        cmd_o.chars = buf_d;
        cmd_o.len   = len_d;
        cmd_o.ovf   = ovf_d;
        len_d       = '0;
        ovf_d       = 1'b0;
      end
    end else if (accept_i && opcode_i == OP_READ) begin
      push_o = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      len_q <= len_d;
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

// File: rtl/pwc_queue.sv
module pwc_queue import pwc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o,
  output logic full_o
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int NUM_W = $clog2(QDEPTH + 1);

  cmd_t             mem_q [QDEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [NUM_W-1:0] num_q;

  assign empty_o = (num_q == '0);
  assign full_o  = (num_q == NUM_W'(QDEPTH));
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      num_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      if (pop_i)  rd_q <= (rd_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      num_q <= num_q + NUM_W'(push_i) - NUM_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |-> !push_i) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue underflow");

endmodule

// File: rtl/pwc_back.sv
module pwc_back import pwc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [3:0] limit_i,
  input  logic       empty_i,
  input  cmd_t       head_i,
  output logic       pop_o,
  output res_t       res_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_QADDR = 3'd2;
  localparam logic [2:0] S_QCMP  = 3'd3;
  localparam logic [2:0] S_QEND  = 3'd4;

  logic [2:0]       state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [3:0]       found_q, found_d;
  logic [5:0]       pend_q, pend_d;
  logic             rd_ok_q, rd_ok_d;
  logic [CNT_W-1:0] counts_q [NUM_BUCKETS];
  logic [CNT_W-1:0] counts_d [NUM_BUCKETS];
  res_t             res_q, res_d;

  logic [WORD_LEN*8-1:0]    store_mem [MEM_DEPTH];
  logic [LEN_W-1:0]         len_mem [MEM_DEPTH];
  logic [WORD_LEN-1:0][7:0] row_q;
  logic [LEN_W-1:0]         rlen_q;

  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [3:0]        lim;
  logic [7:0]        first;
  logic              first_ok;
  logic [BKT_W-1:0]  hb, qb;
  logic [CNT_W-1:0]  hcnt;
  logic              hit;

  always_comb begin
    if (limit_i == 4'd0) lim = 4'd1;
    else if (limit_i > 4'(MAX_RESULTS)) lim = 4'(MAX_RESULTS);
    else lim = limit_i;
  end

  assign first    = head_i.chars[0];
  assign first_ok = (first >= CHAR_LA) && (first <= CHAR_LZ);
  assign hb       = BKT_W'(first - CHAR_LA);
  assign hcnt     = first_ok ? counts_q[hb] : '0;
  assign qb       = BKT_W'(cmd_q.chars[0] - CHAR_LA);

  // prefix compare over the registered row, bytes past the prefix ignored
  always_comb begin
    hit = (rlen_q > cmd_q.len);
    for (int j = 0; j < WORD_LEN; j++) begin
      if (LEN_W'(j) < cmd_q.len && row_q[j] != cmd_q.chars[j]) hit = 1'b0;
    end
  end

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    idx_d    = idx_q;
    found_d  = found_q;
    pend_d   = pend_q;
    rd_ok_d  = rd_ok_q;
    counts_d = counts_q;
    res_d    = '0;
    pop_o    = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = {hb, hcnt[SLOT_W-1:0]};
    rd_en    = 1'b0;
    rd_addr  = {head_i.bucket, head_i.slot};
    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          cmd_d = head_i;
          case (head_i.kind)
            OP_READ: begin
              rd_ok_d = (head_i.bucket < BKT_W'(NUM_BUCKETS)) &&
                        (CNT_W'(head_i.slot) < counts_q[head_i.bucket]);
              rd_en   = rd_ok_d;
              state_d = S_RD;
            end
            OP_INSERT: begin
              res_d.valid = 1'b1;
              res_d.last  = 1'b1;
              if (head_i.len <= LEN_W'(2)) res_d.status = ST_SHORT;
              else if (!first_ok) res_d.status = ST_BADFIRST;
              else if (head_i.ovf) res_d.status = ST_LONG;
              else if (hcnt >= CNT_W'(BUCKET_ENTRIES)) res_d.status = ST_FULL;
              else begin
                res_d.status = ST_STORED;
                res_d.slot   = hcnt[SLOT_W-1:0];
                wr_en        = 1'b1;
                counts_d[hb] = hcnt + CNT_W'(1);
              end
            end
            default: begin
              if (!first_ok || head_i.ovf) begin
                res_d.valid  = 1'b1;
                res_d.last   = 1'b1;
                res_d.status = first_ok ? ST_LONG : ST_BADFIRST;
              end else begin
                idx_d   = '0;
                found_d = '0;
                state_d = S_QADDR;
              end
            end
          endcase
        end
      end
      S_RD: begin
        res_d.valid  = 1'b1;
        res_d.last   = 1'b1;
        res_d.status = ST_READ;
        res_d.slot   = cmd_q.slot;
        if (rd_ok_q && LEN_W'(cmd_q.position) < rlen_q) res_d.chr = row_q[cmd_q.position];
        state_d = S_IDLE;
      end
      S_QADDR: begin
        rd_addr = {qb, idx_q[SLOT_W-1:0]};
        if (idx_q < counts_q[qb]) begin
          rd_en   = 1'b1;
          state_d = S_QCMP;
        end else begin
          state_d = S_QEND;
        end
      end
      S_QCMP: begin
        idx_d   = idx_q + CNT_W'(1);
        state_d = S_QADDR;
        if (hit) begin
          // previous match goes out now, this one waits to learn if it is the final one
          if (found_q != 4'd0) begin
            res_d.valid  = 1'b1;
            res_d.status = ST_MATCH;
            res_d.slot   = pend_q;
            res_d.idx    = found_q;
          end
          pend_d  = idx_q[SLOT_W-1:0];
          found_d = found_q + 4'd1;
          if (found_d == lim) state_d = S_QEND;
        end
      end
      S_QEND: begin
        res_d.valid = 1'b1;
        res_d.last  = 1'b1;
        if (found_q != 4'd0) begin
          res_d.status = ST_MATCH;
          res_d.slot   = pend_q;
          res_d.idx    = found_q;
        end else begin
          res_d.status = ST_NOMATCH;
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= '0;
      for (int k = 0; k < NUM_BUCKETS; k++) counts_q[k] <= '0;
    end else begin
      state_q  <= state_d;
      res_q    <= res_d;
      counts_q <= counts_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    idx_q   <= idx_d;
    found_q <= found_d;
    pend_q  <= pend_d;
    rd_ok_q <= rd_ok_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_addr] <= head_i.chars;
      len_mem[wr_addr]   <= head_i.len;
    end
    if (rd_en) begin
      row_q  <= store_mem[rd_addr];
      rlen_q <= len_mem[rd_addr];
    end
  end

  assign res_o = res_q;

  a_idx_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q.valid && res_q.status == ST_MATCH |-> res_q.idx != 4'd0 && res_q.idx <= lim)
    else $error("match ordinal out of range");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == S_IDLE) else $error("pop while busy");
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_QEND |=> res_q.valid && res_q.last) else $error("query end without last");

endmodule

// File: rtl/prefix_word_completion_core.sv
// Insert and error results pass through the command queue and the result register; read results
// also wait for the store row read in S_RD. A query scans its bucket entry by entry (row read in
// S_QADDR, compare in S_QCMP), stopping early at the result limit; queued commands wait their turn.
// Throughput: characters are taken one per cycle; busy rises only when the two-entry
// command queue is full, which a bucket scan or a run of reads can cause.
// Reset zeroes bucket counts and the buffer length, sets result_limit to 8; results cannot be stalled.
module prefix_word_completion_core import pwc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] opcode_i,
  input  logic [7:0] char_code_i,
  input  logic       last_i,
  input  logic [4:0] bucket_i,
  input  logic [5:0] slot_i,
  input  logic [3:0] position_i,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  output logic       result_valid_o,
  output logic [2:0] status_o,
  output logic [5:0] slot_res_o,
  output logic [7:0] char_code_res_o,
  output logic [3:0] match_index_o,
  output logic       last_res_o
);

  logic [3:0] limit_q;
  logic       accept, push, pop, empty, full;
  cmd_t       push_cmd, head_cmd;
  res_t       res;

  assign busy   = full;
  assign accept = start && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= 4'(MAX_RESULTS);
    else if (cfg_we_i) limit_q <= cfg_wdata_i;
  end

  pwc_front u_front (
    .clk_i, .rst_ni,
    .accept_i(accept), .opcode_i, .char_code_i, .last_i,
    .bucket_i, .slot_i, .position_i,
    .push_o(push), .cmd_o(push_cmd)
  );

  pwc_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .data_i(push_cmd), .pop_i(pop),
    .data_o(head_cmd), .empty_o(empty), .full_o(full)
  );

  pwc_back u_back (
    .clk_i, .rst_ni,
    .limit_i(limit_q), .empty_i(empty), .head_i(head_cmd),
    .pop_o(pop), .res_o(res)
  );

  assign result_valid_o  = res.valid;
  assign status_o        = res.status;
  assign slot_res_o      = res.slot;
  assign char_code_res_o = res.chr;
  assign match_index_o   = res.idx;
  assign last_res_o      = res.last;

endmodule

// File: dv/prefix_word_completion_core_tb.sv
module prefix_word_completion_core_tb;
  import pwc_pkg::*;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
    logic       lst;
    logic [4:0] bkt;
    logic [5:0] slt;
    logic [3:0] pos;
  } char_item_t;

  typedef enum logic [1:0] {PK_ITEM, PK_DRAIN, PK_CFG} pend_kind_e;

  typedef struct packed {
    pend_kind_e  kind;
    char_item_t  item;
    logic [3:0]  cfg_val;
  } pending_t;

  typedef struct packed {
    logic [2:0] st;
    logic [5:0] sl;
    logic [7:0] ch;
    logic [3:0] ix;
    logic       lr;
  } outcome_t;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int CFG_SETTLE     = 8;

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start  = 1'b0;
  logic       busy;
  logic [1:0] opcode_i    = '0;
  logic [7:0] char_code_i = '0;
  logic       last_i      = 1'b0;
  logic [4:0] bucket_i    = '0;
  logic [5:0] slot_i      = '0;
  logic [3:0] position_i  = '0;
  logic       cfg_we_i    = 1'b0;
  logic [3:0] cfg_wdata_i = '0;
  logic       result_valid_o;
  logic [2:0] status_o;
  logic [5:0] slot_res_o;
  logic [7:0] char_code_res_o;
  logic [3:0] match_index_o;
  logic       last_res_o;

  prefix_word_completion_core DUT (
    .clk_i, .rst_ni, .start, .busy, .opcode_i, .char_code_i, .last_i,
    .bucket_i, .slot_i, .position_i, .cfg_we_i, .cfg_wdata_i,
    .result_valid_o, .status_o, .slot_res_o, .char_code_res_o,
    .match_index_o, .last_res_o
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // dictionary shadow
  logic [7:0] dict_chars [NUM_BUCKETS][BUCKET_ENTRIES][WORD_LEN];
  int         dict_len   [NUM_BUCKETS][BUCKET_ENTRIES];
  int         dict_count [NUM_BUCKETS];
  logic [7:0] line_buf [WORD_LEN];
  int         line_len = 0;
  bit         line_ovf = 0;
  int         match_limit = 8;

  pending_t   pend_q [$];
  outcome_t   expected_q [$];
  char_item_t cur_item;
  pending_t   pe;

  int  n_accepted = 0, n_results = 0, n_matches = 0, n_mismatch = 0, n_gen = 0;
  int  gap_left = 0, burst_left = 4, settle_cnt = 0, wd_cnt = 0;
  bit  acc, nxt_start, nxt_we;
  logic acc_seen = 1'b0, res_seen = 1'b0;

  task automatic push_outcome(logic [2:0] st, logic [5:0] sl, logic [7:0] ch,
                              logic [3:0] ix, logic lr);
    outcome_t o;
    o = '{st: st, sl: sl, ch: ch, ix: ix, lr: lr};
    expected_q.push_back(o);
    if (st == ST_MATCH) n_matches++;
  endtask

  task automatic predict_item(char_item_t it);
    logic [7:0] c;
    int b, found;
    bit same;
    if (it.op == OP_READ) begin
      c = '0;
      if (it.bkt < NUM_BUCKETS && it.slt < dict_count[it.bkt] &&
          it.pos < dict_len[it.bkt][it.slt])
        c = dict_chars[it.bkt][it.slt][it.pos];
      push_outcome(ST_READ, it.slt, c, 4'd0, 1'b1);
      return;
    end
    if (it.op == OP_NOP) return;
    c = it.ch;
    if (it.op == OP_QUERY && c >= CHAR_UA && c <= CHAR_UZ) c = c + CASE_OFFSET;
    if (line_len < WORD_LEN) begin
      line_buf[line_len] = c;
      line_len++;
    end else line_ovf = 1;
    if (!it.lst) return;
    if (it.op == OP_INSERT) begin
      if (line_len <= 2) push_outcome(ST_SHORT, 0, 0, 0, 1);
      else if (line_buf[0] < CHAR_LA || line_buf[0] > CHAR_LZ)
        push_outcome(ST_BADFIRST, 0, 0, 0, 1);
      else if (line_ovf) push_outcome(ST_LONG, 0, 0, 0, 1);
      else begin
        b = line_buf[0] - CHAR_LA;
        if (dict_count[b] >= BUCKET_ENTRIES) push_outcome(ST_FULL, 0, 0, 0, 1);
        else begin
          for (int k = 0; k < line_len; k++) dict_chars[b][dict_count[b]][k] = line_buf[k];
          dict_len[b][dict_count[b]] = line_len;
          push_outcome(ST_STORED, 6'(dict_count[b]), 0, 0, 1);
          dict_count[b]++;
        end
      end
    end else begin
      if (line_buf[0] < CHAR_LA || line_buf[0] > CHAR_LZ)
        push_outcome(ST_BADFIRST, 0, 0, 0, 1);
      else if (line_ovf) push_outcome(ST_LONG, 0, 0, 0, 1);
      else begin
        b = line_buf[0] - CHAR_LA;
        found = 0;
        for (int i = 0; i < dict_count[b] && found < match_limit; i++) begin
          same = dict_len[b][i] > line_len;
          for (int k = 0; k < line_len; k++)
            if (dict_chars[b][i][k] != line_buf[k]) same = 0;
          if (same) begin
            found++;
            push_outcome(ST_MATCH, 6'(i), 0, 4'(found), 0);
          end
        end
        if (found == 0) push_outcome(ST_NOMATCH, 0, 0, 0, 1);
        else expected_q[expected_q.size()-1].lr = 1'b1;
      end
    end
    line_len = 0;
    line_ovf = 0;
  endtask

  // driver: one item held on the ports until transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start    <= 1'b0;
      cfg_we_i <= 1'b0;
      acc_seen <= 1'b0;
    end else begin
      acc = start && !busy;
      if (acc) begin
        predict_item(cur_item);
        n_accepted++;
      end
      nxt_start = start && !acc;
      nxt_we = 0;
      if (!nxt_start) begin
        if (gap_left > 0) gap_left--;
        else if (pend_q.size() > 0) begin
          case (pend_q[0].kind)
            PK_ITEM: begin
              pe = pend_q.pop_front();
              cur_item = pe.item;
              opcode_i    <= cur_item.op;
              char_code_i <= cur_item.ch;
              last_i      <= cur_item.lst;
              bucket_i    <= cur_item.bkt;
              slot_i      <= cur_item.slt;
              position_i  <= cur_item.pos;
              nxt_start = 1;
              burst_left--;
              if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 20);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
              end
            end
            PK_DRAIN: begin
              if (expected_q.size() == 0) void'(pend_q.pop_front());
            end
            default: begin
              // register write only once the block has gone quiet
              if (expected_q.size() != 0) settle_cnt = 0;
              else if (settle_cnt < CFG_SETTLE) settle_cnt++;
              else begin
                cfg_wdata_i <= pend_q[0].cfg_val;
                nxt_we = 1;
                match_limit = (pend_q[0].cfg_val == 0) ? 1 :
                              (pend_q[0].cfg_val > MAX_RESULTS) ? MAX_RESULTS :
                              pend_q[0].cfg_val;
                void'(pend_q.pop_front());
                settle_cnt = 0;
              end
            end
          endcase
        end
      end
      start    <= nxt_start;
      cfg_we_i <= nxt_we;
      acc_seen <= acc;
    end
  end

  task automatic report_mismatch(string what, outcome_t e);
    n_mismatch++;
    if (n_mismatch <= 10)
      $display({"mismatch (%s): exp st=%0d slot=%0d ch=%02h idx=%0d last=%0d,",
                " got st=%0d slot=%0d ch=%02h idx=%0d last=%0d"},
               what, e.st, e.sl, e.ch, e.ix, e.lr, status_o, slot_res_o,
               char_code_res_o, match_index_o, last_res_o);
  endtask

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      n_results++;
      if (expected_q.size() == 0) report_mismatch("unexpected", '0);
      else if (expected_q[0] != {status_o, slot_res_o, char_code_res_o, match_index_o,
                                 last_res_o}) report_mismatch("field", expected_q.pop_front());
      else void'(expected_q.pop_front());
    end
    res_seen <= result_valid_o;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (acc_seen || res_seen) wd_cnt <= 0;
      else wd_cnt <= wd_cnt + 1;
      if (wd_cnt >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 wd_cnt, expected_q.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // stimulus generation
  logic [7:0] seq [20];
  logic [7:0] known [64][18];
  int         known_len [64];
  int         known_cnt = 0;

  task automatic push_item(logic [1:0] op, logic [7:0] ch, logic lst,
                           logic [4:0] b, logic [5:0] s, logic [3:0] p);
    pending_t e;
    e.kind = PK_ITEM;
    e.item = '{op: op, ch: ch, lst: lst, bkt: b, slt: s, pos: p};
    e.cfg_val = '0;
    pend_q.push_back(e);
    n_gen++;
  endtask

  task automatic push_char(logic [1:0] op, logic [7:0] ch, logic lst);
    push_item(op, ch, lst, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
              4'($urandom_range(0, 15)));
  endtask

  task automatic push_seq(logic [1:0] op, int n);
    for (int i = 0; i < n; i++) push_char(op, seq[i], i == n - 1);
  endtask

  task automatic push_str(logic [1:0] op, string s);
    for (int i = 0; i < s.len(); i++) seq[i] = s[i];
    push_seq(op, s.len());
  endtask

  task automatic push_ctrl(pend_kind_e k, logic [3:0] v);
    pending_t e;
    e = '0;
    e.kind = k;
    e.cfg_val = v;
    pend_q.push_back(e);
  endtask

  task automatic gen_insert();
    int n, r;
    r = $urandom_range(0, 9);
    n = (r < 7) ? $urandom_range(1, 6) : (r < 9) ? $urandom_range(7, 16) : $urandom_range(17, 18);
    r = $urandom_range(0, 9);
    seq[0] = 8'((r < 8) ? CHAR_LA + $urandom_range(0, 3) :
                (r == 8) ? CHAR_UA + $urandom_range(0, 25) : $urandom_range(0, 255));
    for (int i = 1; i < n; i++)
      seq[i] = 8'(($urandom_range(0, 9) != 0) ? CHAR_LA + $urandom_range(0, 2)
                                                : $urandom_range(0, 255));
    if (n >= 3 && known_cnt < 64) begin
      for (int i = 0; i < n; i++) known[known_cnt][i] = seq[i];
      known_len[known_cnt] = n;
      known_cnt++;
    end
    push_seq(OP_INSERT, n);
  endtask

  task automatic gen_query();
    int n, w;
    if (known_cnt > 0 && $urandom_range(0, 3) != 0) begin
      w = $urandom_range(0, known_cnt - 1);
      n = $urandom_range(1, known_len[w]);
      for (int i = 0; i < n; i++) begin
        seq[i] = known[w][i];
        if (seq[i] >= CHAR_LA && seq[i] <= CHAR_LZ && $urandom_range(0, 2) == 0)
          seq[i] = seq[i] - CASE_OFFSET;
      end
    end else begin
      n = $urandom_range(1, 18);
      for (int i = 0; i < n; i++)
        seq[i] = 8'(($urandom_range(0, 1) != 0) ? CHAR_LA + $urandom_range(0, 3)
                                                  : $urandom_range(0, 255));
    end
    push_seq(OP_QUERY, n);
  endtask

  initial begin
    logic [3:0] limits [5];
    int r;
    limits = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd8};
    foreach (dict_count[i]) dict_count[i] = 0;

    // directed
    push_str(OP_READ, "x");
    push_item(OP_READ, 8'hff, 1'b1, 5'd31, 6'd63, 4'd15);
    push_item(OP_NOP, 8'hff, 1'b1, 5'd31, 6'd63, 4'd15);
    push_str(OP_INSERT, "a");
    push_str(OP_INSERT, "ab");
    push_str(OP_INSERT, "abc");
    push_str(OP_INSERT, "abcd");
    push_str(OP_INSERT, "Abc");
    push_item(OP_INSERT, 8'hff, 1'b0, 0, 0, 0);
    push_str(OP_INSERT, "bc");
    push_str(OP_INSERT, "abcdefghijklmnopq");
    push_str(OP_INSERT, "abcdefghijklmnop");
    push_str(OP_QUERY, "AB");
    push_str(OP_QUERY, "a");
    push_str(OP_QUERY, "abcd");
    push_str(OP_QUERY, "zz");
    push_str(OP_QUERY, "{");
    push_str(OP_QUERY, "abcdefghijklmnopq");
    push_item(OP_READ, 0, 0, 5'd0, 6'd1, 4'd3);
    push_item(OP_READ, 0, 0, 5'd0, 6'd1, 4'd4);
    push_item(OP_READ, 0, 0, 5'd0, 6'd2, 4'd15);
    push_ctrl(PK_DRAIN, 0);

    push_str(OP_QUERY, "z");
    push_item(OP_READ, 0, 1, 5'd25, 6'd63, 4'd2);
    push_ctrl(PK_DRAIN, 0);
    n_gen = 0;

    // random phases over several limit settings
    for (int ph = 0; ph < 5; ph++) begin
      push_ctrl(PK_CFG, limits[ph]);
      while (n_gen < (ph + 1) * 9) begin
        r = $urandom_range(0, 9);
        if (r < 4) gen_insert();
        else if (r < 7) gen_query();
        else if (r < 9)
          push_item(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    5'(($urandom_range(0, 4) != 0) ? $urandom_range(0, 3)
                                                   : $urandom_range(0, 31)),
                    6'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 7)
                                                   : $urandom_range(0, 63)),
                    4'($urandom_range(0, 15)));
        else if ($urandom_range(0, 1) != 0)
          push_char(OP_NOP, 8'($urandom_range(0, 255)), 1'b1);
        else push_char(2'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0);
        if (n_gen == ph * 9 + 4) push_ctrl(PK_DRAIN, 0);
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    while (pend_q.size() != 0 || expected_q.size() != 0 || start) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("covered %0d transfers, %0d results (%0d matches), limits 8,1,0,15,3,8",
             n_accepted, n_results, n_matches);
    $display("including overlong words, mixed-case prefixes and out-of-range reads; %0d mismatches",
             n_mismatch);
    if (n_mismatch == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
